/* hw/rtl/lkrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkrc_pkg
// Shared types and constants of the keyed LRU result cache.
// ----------------------------------------------------------------------------
package lkrc_pkg;

	localparam int KEY_W  = 64;
	localparam int PORT_W = 8;
	localparam int MODE_W = 2;
	localparam int OCC_W  = 5;
	localparam int CNT_W  = 32;

	// request codes; the fourth code is a no-op
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_SEARCH,
		OP_PROMOTE,
		OP_SHIFT
	} unit_op_t;

	typedef struct packed {
		logic match;
		logic evict;
		logic rank_we;
	} unit_res_t;

endpackage

/* hw/rtl/lru_keyed_result_cache.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_result_cache
// Fully associative LRU cache keyed by {key, port}, one value word per entry.
// Sequence: clear, no-op or zero capacity go straight to the result; a lookup
//   miss takes one scan, a lookup hit two scans, an insert two scans and a write.
// Throughput: one request at a time; each scan walks the entry memory one
//   entry a cycle through the single shared compare/rank unit.
// Reset: entries invalid, counters zero, capacity 16; no clearing pass.
// ----------------------------------------------------------------------------
module lru_keyed_result_cache
	import lkrc_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [OCC_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [MODE_W-1:0]      mode,
	input  logic [KEY_W-1:0]       lookup_key,
	input  logic [PORT_W-1:0]      port_index,
	input  logic [VALUE_WIDTH-1:0] value_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [VALUE_WIDTH-1:0] value_out,
	output logic [OCC_W-1:0]       occupancy,
	output logic [CNT_W-1:0]       hit_total,
	output logic [CNT_W-1:0]       miss_total
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IW = $clog2(ENTRIES + 1);

	state_t state_q, state_nx;

	logic [OCC_W-1:0]       capacity_q;
	logic [OCC_W-1:0]       cap_eff;
	logic [MODE_W-1:0]      mode_q;
	logic [KEY_W-1:0]       key_q;
	logic [PORT_W-1:0]      port_q;
	logic [VALUE_WIDTH-1:0] value_q;

	logic [ENTRIES-1:0]     valid_q;
	logic [OCC_W-1:0]       count_q;
	logic [CNT_W-1:0]       hit_cnt_q;
	logic [CNT_W-1:0]       miss_cnt_q;

	logic [IW-1:0]          idx_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	logic                   found_q;
	logic                   free_q;
	logic                   need_evict_q;
	logic [AW-1:0]          target_q;
	logic [AW-1:0]          hit_rank_q;
	logic [VALUE_WIDTH-1:0] val_q;

	logic                   out_valid_q;
	logic                   out_hit_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [OCC_W-1:0]       out_occ_q;

	logic                   accept;
	logic                   scanning;
	logic                   idx_end;
	logic                   scan_end;
	logic                   load_out;
	logic                   hit_any;
	logic                   lookup_hit;

	logic                   rd_en;
	logic [KEY_W-1:0]       rd_key;
	logic [PORT_W-1:0]      rd_port;
	logic [VALUE_WIDTH-1:0] rd_value;
	logic [AW-1:0]          rd_rank;
	logic                   ent_we;
	logic                   rank_we;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          wr_rank;

	unit_op_t               unit_op;
	unit_res_t              unit_res;
	logic [AW-1:0]          unit_rank;

	assign cap_eff    = (32'(capacity_q) > ENTRIES) ? OCC_W'(ENTRIES) : capacity_q;
	assign cfg_ready  = 1'b1;
	assign accept     = in_valid && in_ready;
	assign scanning   = (state_q == ST_SEARCH) || (state_q == ST_UPDATE);
	assign idx_end    = (idx_q == IW'(ENTRIES));
	assign scan_end   = scanning && idx_end && vld_s1;
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign hit_any    = found_q || (vld_s1 && unit_res.match);
	assign lookup_hit = (mode_q == MODE_LOOKUP) && found_q;

	lkrc_store #(
		.ENTRIES     (ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH),
		.AW          (AW)
	) u_store (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (idx_q[AW-1:0]),
		.rd_key   (rd_key),
		.rd_port  (rd_port),
		.rd_value (rd_value),
		.rd_rank  (rd_rank),
		.ent_we   (ent_we),
		.rank_we  (rank_we),
		.wr_addr  (wr_addr),
		.wr_key   (key_q),
		.wr_port  (port_q),
		.wr_value (value_q),
		.wr_rank  (wr_rank)
	);

	lkrc_entry_unit #(
		.RW (AW)
	) u_unit (
		.op         (unit_op),
		.ent_valid  (valid_q[idx_s1]),
		.ent_key    (rd_key),
		.ent_port   (rd_port),
		.req_key    (key_q),
		.req_port   (port_q),
		.rank       (rd_rank),
		.ref_rank   (hit_rank_q),
		.is_target  (idx_s1 == target_q),
		.need_evict (need_evict_q),
		.evict_from (cap_eff - OCC_W'(1)),
		.res        (unit_res),
		.rank_new   (unit_rank)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (((mode == MODE_LOOKUP) || (mode == MODE_INSERT)) && (cap_eff != '0)) begin
						state_nx = ST_SEARCH;
					end else begin
						state_nx = ST_DONE;
					end
				end
			end
			ST_SEARCH: begin
				if (scan_end) begin
					if (hit_any || (mode_q == MODE_INSERT)) begin
						state_nx = ST_UPDATE;
					end else begin
						state_nx = ST_DONE;
					end
				end
			end
			ST_UPDATE: begin
				if (scan_end) begin
					state_nx = (mode_q == MODE_INSERT) ? ST_WRITE : ST_DONE;
				end
			end
			ST_WRITE: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (load_out) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unit_op  = OP_SEARCH;
		ent_we   = 1'b0;
		rank_we  = 1'b0;
		wr_addr  = idx_s1;
		wr_rank  = unit_rank;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SEARCH: begin
				rd_en = !idx_end;
			end
			ST_UPDATE: begin
				rd_en   = !idx_end;
				unit_op = found_q ? OP_PROMOTE : OP_SHIFT;
				rank_we = vld_s1 && unit_res.rank_we;
			end
			ST_WRITE: begin
				ent_we  = 1'b1;
				rank_we = 1'b1;
				wr_addr = target_q;
				wr_rank = '0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= OCC_W'(16);
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
		end
	end

	// request capture and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			vld_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			need_evict_q <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
		end else begin
			if (accept) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
				if (mode == MODE_CLEAR) begin
					valid_q <= '0;
					count_q <= '0;
				end
			end

			if (scanning && !idx_end) begin
				idx_q  <= idx_q + IW'(1);
				vld_s1 <= 1'b1;
			end else begin
				vld_s1 <= 1'b0;
			end
			if (scan_end || !scanning) begin
				idx_q <= '0;
			end

			if ((state_q == ST_SEARCH) && vld_s1 && unit_res.match) begin
				found_q <= 1'b1;
			end
			if ((state_q == ST_SEARCH) && scan_end) begin
				need_evict_q <= (count_q >= cap_eff);
			end

			if ((state_q == ST_UPDATE) && vld_s1 && !found_q) begin
				if (unit_res.evict) begin
					valid_q[idx_s1] <= 1'b0;
					count_q         <= count_q - OCC_W'(1);
				end
				if (!free_q && (!valid_q[idx_s1] || unit_res.evict)) begin
					free_q <= 1'b1;
				end
			end

			if ((state_q == ST_WRITE) && !found_q) begin
				valid_q[target_q] <= 1'b1;
				count_q           <= count_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= lookup_key;
			port_q  <= port_index;
			value_q <= value_in;
		end
		if (scanning) begin
			idx_s1 <= idx_q[AW-1:0];
		end
		if ((state_q == ST_SEARCH) && vld_s1 && unit_res.match) begin
			target_q   <= idx_s1;
			hit_rank_q <= rd_rank;
			val_q      <= rd_value;
		end
		// first slot that is empty once the old entries have gone
		if ((state_q == ST_UPDATE) && vld_s1 && !found_q && !free_q &&
			(!valid_q[idx_s1] || unit_res.evict)) begin
			target_q <= idx_s1;
		end
		if (load_out) begin
			out_hit_q   <= lookup_hit;
			out_value_q <= lookup_hit ? val_q : '0;
			out_occ_q   <= count_q;
		end
	end

	// result register and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (mode_q == MODE_LOOKUP) begin
					if (found_q) begin
						if (hit_cnt_q != '1) begin
							hit_cnt_q <= hit_cnt_q + CNT_W'(1);
						end
					end else if (miss_cnt_q != '1) begin
						miss_cnt_q <= miss_cnt_q + CNT_W'(1);
					end
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = out_hit_q;
	assign value_out  = out_value_q;
	assign occupancy  = out_occ_q;
	assign hit_total  = hit_cnt_q;
	assign miss_total = miss_cnt_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(valid_q) == int'(count_q)))
		else $error("entry count differs from valid bits");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (int'(count_q) <= ENTRIES))
		else $error("entry count above number of entries");

	a_shift_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_UPDATE) && !found_q) |-> (mode_q == MODE_INSERT))
		else $error("eviction pass outside an insert");

	a_hit_cnt_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (hit_cnt_q >= $past(hit_cnt_q)))
		else $error("hit counter went backwards");

	a_no_load_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (state_q == ST_DONE)) |=> (state_q == ST_DONE))
		else $error("result dropped while output stalled");

endmodule

/* hw/rtl/lkrc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkrc_store
// Entry memory (key, port, value) and recency rank memory. One read address
// shared by both, registered read data, one write address.
// ----------------------------------------------------------------------------
module lkrc_store
	import lkrc_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int VALUE_WIDTH = 64,
	parameter int AW          = 4
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output logic [KEY_W-1:0]       rd_key,
	output logic [PORT_W-1:0]      rd_port,
	output logic [VALUE_WIDTH-1:0] rd_value,
	output logic [AW-1:0]          rd_rank,
	input  logic                   ent_we,
	input  logic                   rank_we,
	input  logic [AW-1:0]          wr_addr,
	input  logic [KEY_W-1:0]       wr_key,
	input  logic [PORT_W-1:0]      wr_port,
	input  logic [VALUE_WIDTH-1:0] wr_value,
	input  logic [AW-1:0]          wr_rank
);

	localparam int EW = KEY_W + PORT_W + VALUE_WIDTH;

	logic [EW-1:0] ent_mem [ENTRIES];
	logic [AW-1:0] rank_mem [ENTRIES];
	logic [EW-1:0] ent_rd_q;
	logic [AW-1:0] rank_rd_q;

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[wr_addr] <= {wr_key, wr_port, wr_value};
		end
		if (rank_we) begin
			rank_mem[wr_addr] <= wr_rank;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_rd_q  <= ent_mem[rd_addr];
			rank_rd_q <= rank_mem[rd_addr];
		end
	end

	assign rd_key   = ent_rd_q[EW-1 -: KEY_W];
	assign rd_port  = ent_rd_q[VALUE_WIDTH +: PORT_W];
	assign rd_value = ent_rd_q[VALUE_WIDTH-1:0];
	assign rd_rank  = rank_rd_q;

endmodule

/* hw/rtl/lkrc_entry_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkrc_entry_unit
// Per-entry compare and rank unit, reused for every entry of every scan.
// ----------------------------------------------------------------------------
module lkrc_entry_unit
	import lkrc_pkg::*;
#(
	parameter int RW = 4
) (
	input  unit_op_t          op,
	input  logic              ent_valid,
	input  logic [KEY_W-1:0]  ent_key,
	input  logic [PORT_W-1:0] ent_port,
	input  logic [KEY_W-1:0]  req_key,
	input  logic [PORT_W-1:0] req_port,
	input  logic [RW-1:0]     rank,
	input  logic [RW-1:0]     ref_rank,
	input  logic              is_target,
	input  logic              need_evict,
	input  logic [OCC_W-1:0]  evict_from,
	output unit_res_t         res,
	output logic [RW-1:0]     rank_new
);

	localparam int CW = (RW > OCC_W) ? RW : OCC_W;

	logic old_enough;

	assign old_enough = CW'(rank) >= CW'(evict_from);

	always_comb begin
		res      = '0;
		rank_new = rank + RW'(1);
		case (op)
			OP_SEARCH: begin
				res.match = ent_valid && (ent_key == req_key) && (ent_port == req_port);
			end
			OP_PROMOTE: begin
				if (is_target) begin
					res.rank_we = 1'b1;
					rank_new    = '0;
				end else if (ent_valid && (rank < ref_rank)) begin
					res.rank_we = 1'b1;
				end
			end
			OP_SHIFT: begin
				// ranks at or past capacity-1 go when an eviction is needed; the rest age by one
				if (ent_valid && need_evict && old_enough) begin
					res.evict = 1'b1;
				end else if (ent_valid) begin
					res.rank_we = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed LRU result cache. Directed requests cover
// hit/miss, refresh, port-only key differences, clear, the no-op code, zero
// and oversize capacity and shrinking below occupancy. Randomised
// lookup/insert/clear traffic follows over a range of capacities. Every
// response is checked field by field against an in-bench model of the cache.
// ----------------------------------------------------------------------------
module tb
	import lkrc_pkg::*;
();

	localparam int ENTRIES        = 16;
	localparam int VALUE_WIDTH    = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 2 * ENTRIES + 8;
	localparam int MAX_REPORTS    = 10;
	localparam int POOL_MAX       = 32;

	localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

	localparam logic [OCC_W-1:0] CAP_NONE = 5'd0;
	localparam logic [OCC_W-1:0] CAP_FULL = 5'd16;
	localparam logic [OCC_W-1:0] CAP_TOP  = 5'd31;

	typedef struct packed {
		logic                   hit;
		logic [VALUE_WIDTH-1:0] value;
		logic [OCC_W-1:0]       occ;
		logic [CNT_W-1:0]       hits;
		logic [CNT_W-1:0]       misses;
	} cache_resp_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [OCC_W-1:0]       cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [MODE_W-1:0]      mode;
	logic [KEY_W-1:0]       lookup_key;
	logic [PORT_W-1:0]      port_index;
	logic [VALUE_WIDTH-1:0] value_in;
	logic                   out_valid;
	logic                   out_ready;
	logic                   hit;
	logic [VALUE_WIDTH-1:0] value_out;
	logic [OCC_W-1:0]       occupancy;
	logic [CNT_W-1:0]       hit_total;
	logic [CNT_W-1:0]       miss_total;

	lru_keyed_result_cache #(
		.ENTRIES     (ENTRIES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.lookup_key (lookup_key),
		.port_index (port_index),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.value_out  (value_out),
		.occupancy  (occupancy),
		.hit_total  (hit_total),
		.miss_total (miss_total)
	);

	always #1 clk = ~clk;

	// cache model
	logic [KEY_W-1:0]       mdl_key   [ENTRIES];
	logic [PORT_W-1:0]      mdl_port  [ENTRIES];
	logic [VALUE_WIDTH-1:0] mdl_value [ENTRIES];
	bit                     mdl_valid [ENTRIES];
	int unsigned            mdl_rank  [ENTRIES];
	int unsigned            mdl_count;
	logic [CNT_W-1:0]       mdl_hits;
	logic [CNT_W-1:0]       mdl_misses;
	logic [OCC_W-1:0]       mdl_cap;

	cache_resp_t resp_q[$];

	logic [KEY_W-1:0]  pool_key  [POOL_MAX];
	logic [PORT_W-1:0] pool_port [POOL_MAX];

	bit          tx_idle_en;
	bit          rx_idle_en;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	function automatic int unsigned usable_cap();
		return (mdl_cap > ENTRIES) ? ENTRIES : mdl_cap;
	endfunction

	function automatic int find_entry(logic [KEY_W-1:0] k, logic [PORT_W-1:0] p);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (mdl_valid[i] && mdl_key[i] == k && mdl_port[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void promote_entry(int slot);
		int unsigned r;
		int i;
		r = mdl_rank[slot];
		for (i = 0; i < ENTRIES; i++)
			if (mdl_valid[i] && mdl_rank[i] < r)
				mdl_rank[i]++;
		mdl_rank[slot] = 0;
	endfunction

	function automatic void evict_oldest();
		int i;
		if (mdl_count == 0)
			return;
		for (i = 0; i < ENTRIES; i++) begin
			if (mdl_valid[i] && mdl_rank[i] == mdl_count - 1) begin
				mdl_valid[i] = 1'b0;
				mdl_count--;
				return;
			end
		end
	endfunction

	function automatic void insert_entry(logic [KEY_W-1:0] k, logic [PORT_W-1:0] p,
			logic [VALUE_WIDTH-1:0] v);
		int unsigned cap;
		int slot;
		int i;
		int j;
		cap = usable_cap();
		if (cap == 0)
			return;
		slot = find_entry(k, p);
		if (slot >= 0) begin
			mdl_value[slot] = v;
			promote_entry(slot);
			return;
		end
		// a lowered capacity may need several evictions
		while (mdl_count >= cap && mdl_count > 0)
			evict_oldest();
		for (i = 0; i < ENTRIES; i++)
			if (!mdl_valid[i])
				break;
		if (i >= ENTRIES)
			return;
		for (j = 0; j < ENTRIES; j++)
			if (mdl_valid[j])
				mdl_rank[j]++;
		mdl_key[i]   = k;
		mdl_port[i]  = p;
		mdl_value[i] = v;
		mdl_valid[i] = 1'b1;
		mdl_rank[i]  = 0;
		mdl_count++;
	endfunction

	function automatic cache_resp_t predict_resp(logic [MODE_W-1:0] op, logic [KEY_W-1:0] k,
			logic [PORT_W-1:0] p, logic [VALUE_WIDTH-1:0] v);
		cache_resp_t r;
		int slot;
		int i;
		r = '0;
		case (op)
			MODE_LOOKUP: begin
				slot = (usable_cap() == 0) ? -1 : find_entry(k, p);
				if (slot >= 0) begin
					promote_entry(slot);
					r.hit   = 1'b1;
					r.value = mdl_value[slot];
					if (mdl_hits != '1)
						mdl_hits++;
				end else if (mdl_misses != '1) begin
					mdl_misses++;
				end
			end
			MODE_INSERT: insert_entry(k, p, v);
			MODE_CLEAR: begin
				for (i = 0; i < ENTRIES; i++)
					mdl_valid[i] = 1'b0;
				mdl_count = 0;
			end
			default: ;
		endcase
		r.occ    = mdl_count[OCC_W-1:0];
		r.hits   = mdl_hits;
		r.misses = mdl_misses;
		return r;
	endfunction

	function automatic void reset_model();
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_rank[i]  = 0;
		end
		mdl_count  = 0;
		mdl_hits   = '0;
		mdl_misses = '0;
		mdl_cap    = CAP_FULL;
	endfunction

	function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endfunction

	// response checker and sink-side back-pressure
	always @(posedge clk) begin : resp_checker
		cache_resp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (resp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response with no request outstanding, hit %b value %h",
						$realtime, hit, value_out);
			end else begin
				want = resp_q.pop_front();
				cmp_field("hit", want.hit, hit);
				cmp_field("value_out", want.value, value_out);
				cmp_field("occupancy", want.occ, occupancy);
				cmp_field("hit_total", want.hits, hit_total);
				cmp_field("miss_total", want.misses, miss_total);
			end
		end
		out_ready <= !(rx_idle_en && $urandom_range(99) < 30);
	end

	// watchdog: only counts while something is in flight
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !(in_valid || cfg_valid || resp_q.size() != 0)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no handshake for %0d cycles", $realtime, quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// call at a rising edge; returns at the edge the request is taken
	task automatic send_req(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [PORT_W-1:0] p, input logic [VALUE_WIDTH-1:0] v);
		while (tx_idle_en && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= op;
		lookup_key <= k;
		port_index <= p;
		value_in   <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		resp_q.push_back(predict_resp(op, k, p, v));
	endtask

	// drop valid and wait for every outstanding response
	task automatic hold_sender();
		in_valid <= 1'b0;
		@(posedge clk);
		while (resp_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(input logic [OCC_W-1:0] cap);
		hold_sender();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		mdl_cap = cap;
	endtask

	function automatic void new_pool(int n);
		int i;
		for (i = 0; i < n; i++) begin
			// some keys differ only in the port
			if (i > 0 && $urandom_range(3) == 0)
				pool_key[i] = pool_key[i-1];
			else
				pool_key[i] = {$urandom, $urandom};
			pool_port[i] = PORT_W'($urandom_range(255));
		end
	endfunction

	task automatic send_random(input int pool_n);
		int r;
		int sel;
		logic [MODE_W-1:0] op;
		logic [KEY_W-1:0]  k;
		logic [PORT_W-1:0] p;
		r = $urandom_range(99);
		if (r < 50)
			op = MODE_LOOKUP;
		else if (r < 93)
			op = MODE_INSERT;
		else if (r < 96)
			op = MODE_CLEAR;
		else
			op = MODE_NOP;
		if ($urandom_range(99) < 88) begin
			sel = $urandom_range(pool_n - 1);
			k   = pool_key[sel];
			p   = pool_port[sel];
		end else begin
			k = {$urandom, $urandom};
			p = PORT_W'($urandom_range(255));
		end
		send_req(op, k, p, {$urandom, $urandom});
	endtask

	task automatic test_basic_ops();
		send_req(MODE_LOOKUP, '1, 8'hff, '0);
		send_req(MODE_INSERT, '1, 8'hff, '1);
		send_req(MODE_LOOKUP, '1, 8'hff, '0);
		send_req(MODE_INSERT, '0, 8'h00, '0);
		send_req(MODE_LOOKUP, '0, 8'h00, '1);
		send_req(MODE_LOOKUP, '1, 8'h00, '0);
		send_req(MODE_INSERT, '1, 8'hff, 64'h0123_4567_89ab_cdef);
		send_req(MODE_LOOKUP, '1, 8'hff, '0);
		send_req(MODE_NOP, '1, 8'hff, '1);
		send_req(MODE_CLEAR, '0, 8'h00, '0);
		send_req(MODE_LOOKUP, '0, 8'h00, '0);
	endtask

	task automatic test_zero_capacity();
		send_req(MODE_INSERT, 64'h5555_aaaa_5555_aaaa, 8'h55, 64'hdead_beef_0000_0001);
		send_req(MODE_INSERT, 64'haaaa_5555_aaaa_5555, 8'haa, 64'hdead_beef_0000_0002);
		write_capacity(CAP_NONE);
		// held entries are invisible and inserts are dropped
		send_req(MODE_LOOKUP, 64'h5555_aaaa_5555_aaaa, 8'h55, '0);
		send_req(MODE_INSERT, 64'h1111_2222_3333_4444, 8'h12, 64'hdead_beef_0000_0003);
		write_capacity(CAP_TOP);
		send_req(MODE_LOOKUP, 64'h5555_aaaa_5555_aaaa, 8'h55, '0);
		send_req(MODE_LOOKUP, 64'h1111_2222_3333_4444, 8'h12, '0);
	endtask

	task automatic test_capacity_shrink();
		int i;
		write_capacity(CAP_FULL);
		send_req(MODE_CLEAR, '0, 8'h00, '0);
		for (i = 1; i <= 4; i++)
			send_req(MODE_INSERT, 64'(i), 8'(i), 64'(i * 100));
		write_capacity(5'd2);
		send_req(MODE_LOOKUP, 64'(1), 8'(1), '0);
		send_req(MODE_INSERT, 64'(9), 8'(9), 64'(900));
		send_req(MODE_LOOKUP, 64'(1), 8'(1), '0);
		send_req(MODE_LOOKUP, 64'(4), 8'(4), '0);
	endtask

	task automatic test_random_capacities();
		logic [OCC_W-1:0] caps [10];
		int ph;
		int n;
		int pool_n;
		caps = '{CAP_FULL, 5'd1, 5'd5, CAP_NONE, CAP_TOP, 5'd3, 5'd17, 5'd12, 5'd2, 5'd8};
		for (ph = 0; ph < 10; ph++) begin
			write_capacity(caps[ph]);
			pool_n = $urandom_range(4, 24);
			new_pool(pool_n);
			for (n = 0; n < ((caps[ph] == CAP_NONE) ? 40 : 80); n++)
				send_random(pool_n);
		end
	endtask

	task automatic test_sender_pause();
		int n;
		write_capacity(CAP_FULL);
		new_pool(20);
		for (n = 0; n < 60; n++) begin
			send_random(20);
			if (n % 20 == 19)
				hold_sender();
		end
	endtask

	task automatic test_no_idle();
		int n;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		new_pool(18);
		for (n = 0; n < 120; n++)
			send_random(18);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		mode         = MODE_LOOKUP;
		lookup_key   = '0;
		port_index   = '0;
		value_in     = '0;
		out_ready    = 1'b0;
		tx_idle_en   = 1'b1;
		rx_idle_en   = 1'b1;
		mismatches   = 0;
		quiet_cycles = 0;
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_zero_capacity();
		test_capacity_shrink();
		test_random_capacities();
		test_sender_pause();
		test_no_idle();

		hold_sender();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (resp_q.size() != 0) begin
			mismatches += resp_q.size();
			$display("%0d responses never arrived", resp_q.size());
		end
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
